// File: rtl/core/miau_pkg.sv
// Shared constants and types for the MIX integer arithmetic unit.
package miau_pkg;
  localparam int WordBitsDefault = 30;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // latch operand and operation
    logic addsub;   // finish add or subtract
    logic mul_init;
    logic div_init;
    logic div_pass2; // keep remainder, feed rX into the low half
    logic iter;     // one shift-add or restoring step
    logic mul_done;
    logic div_done;
  } miau_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
  } miau_stat_t;
endpackage

// File: rtl/core/mix_integer_arithmetic_unit_top.sv
// Top level of the MIX integer arithmetic unit.
// Usage:
//   Input channel (in_valid/in_ready) carries kind, the memory word and the
//   field spec; one transfer per instruction. Output channel
//   (out_valid/out_ready) carries rA, rX, overflow and status after it.
//   Add and subtract go from dispatch straight to the result state.
//   Multiply runs one shift-add per cycle, then a finish step. Divide
//   uses a restoring divider that runs one quotient bit a cycle over the
//   high then low half, with a reload step between and a finish step.
//   A zero divisor goes from dispatch straight to the result with status
//   1, registers unchanged.
//   One item is in flight at a time; in_ready is high only when idle, in
//   the cycle after the result transfer.
//   If the receiver stalls, the result holds on the output ports until
//   transferred, and no new item is taken.
//   Reset clears rA, rX, their signs, status and the sticky overflow flag.
module mix_integer_arithmetic_unit_top
  import miau_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic                 mem_sign,
  input  logic [WORD_BITS-1:0] mem_magnitude,
  input  logic [2:0]           field_left,
  input  logic [2:0]           field_right,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 a_sign,
  output logic [WORD_BITS-1:0] a_value,
  output logic                 x_sign,
  output logic [WORD_BITS-1:0] x_value,
  output logic                 overflow_out,
  output logic                 status
);
  miau_cmd_t  cmd;
  miau_stat_t stat;

  miau_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  miau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .kind, .mem_sign, .mem_magnitude,
    .field_left, .field_right,
    .a_sign_q(a_sign), .a_mag_q(a_value), .x_sign_q(x_sign),
    .x_mag_q(x_value), .ovf_q(overflow_out), .status_q(status)
  );
endmodule

// File: rtl/core/miau_datapath.sv
// Datapath: field select, registers, shift-add multiplier and restoring divider.
module miau_datapath
  import miau_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  miau_cmd_t            cmd,
  output miau_stat_t           stat,
  input  logic [1:0]           kind,
  input  logic                 mem_sign,
  input  logic [WORD_BITS-1:0] mem_magnitude,
  input  logic [2:0]           field_left,
  input  logic [2:0]           field_right,
  output logic                 a_sign_q,
  output logic [WORD_BITS-1:0] a_mag_q,
  output logic                 x_sign_q,
  output logic [WORD_BITS-1:0] x_mag_q,
  output logic                 ovf_q,
  output logic                 status_q
);
  localparam int ByteBits = WORD_BITS / 5;
  localparam int W = WORD_BITS;

  // field select
  logic           fsel_sign;
  logic [W-1:0]   fsel_mag;
  logic [W-1:0]   shifted;
  logic [W-1:0]   fmask;
  logic [2:0]     first;
  logic [5:0]     shamt;
  logic [5:0]     nbits;

  always_comb begin
    fsel_sign = 1'b0;
    fsel_mag  = '0;
    first     = (field_left == 3'd0) ? 3'd1 : field_left;
    shamt     = 6'((3'd5 - field_right) * ByteBits);
    nbits     = 6'((field_right - first + 3'd1) * ByteBits);
    shifted   = mem_magnitude >> shamt;
    fmask     = ~({W{1'b1}} << nbits);
    if (!(field_left > 3'd5 || field_right > 3'd5 || field_left > field_right)) begin
      fsel_sign = (field_left == 3'd0) ? mem_sign : 1'b0;
      if (field_right != 3'd0)
        fsel_mag = (first > 3'd1) ? (shifted & fmask) : shifted;
    end
  end

  logic           op_sign;
  logic [W-1:0]   op_mag;
  logic [1:0]     op_kind;
  // working registers: hi:lo hold product or remainder:quotient
  logic [W:0]     hi;
  logic [W-1:0]   lo;
  logic           qovf;

  assign stat.is_mul   = (op_kind == KIND_MUL);
  assign stat.is_div   = (op_kind == KIND_DIV);
  assign stat.div_zero = (op_mag == '0);

  // add/sub
  logic           eff_sign;
  logic [W:0]     sum;
  logic [W:0]     diff_av, diff_va;
  assign eff_sign = op_sign ^ (op_kind == KIND_SUB);
  assign sum      = {1'b0, a_mag_q} + {1'b0, op_mag};
  assign diff_av  = {1'b0, a_mag_q} - {1'b0, op_mag};
  assign diff_va  = {1'b0, op_mag} - {1'b0, a_mag_q};

  // divide step
  logic [W+1:0]   trial;
  assign trial = {hi, lo[W-1]} - {2'b00, op_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_sign_q <= 1'b0;
      a_mag_q  <= '0;
      x_sign_q <= 1'b0;
      x_mag_q  <= '0;
      ovf_q    <= 1'b0;
      status_q <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_sign  <= fsel_sign;
        op_mag   <= fsel_mag;
        op_kind  <= kind;
        status_q <= 1'b0;
      end
      if (cmd.addsub) begin
        if (a_sign_q == eff_sign) begin
          if (sum != '0) begin
            a_mag_q <= sum[W-1:0];
            if (sum[W]) ovf_q <= 1'b1;
          end
        end else if (!diff_av[W]) begin
          a_mag_q <= diff_av[W-1:0];
        end else begin
          a_mag_q  <= diff_va[W-1:0];
          a_sign_q <= eff_sign;
        end
      end
      if (cmd.mul_init) begin
        hi <= '0;
        lo <= op_mag;
      end
      if (cmd.div_init) begin
        if (stat.div_zero) status_q <= 1'b1;
        // pass one divides rA; any quotient bit there means overflow
        hi   <= '0;
        lo   <= a_mag_q;
        qovf <= 1'b0;
      end
      if (cmd.div_pass2) begin
        // lo holds the high quotient half, hi the remainder carried over
        qovf <= (lo != '0);
        lo   <= x_mag_q;
      end
      if (cmd.iter) begin
        if (stat.is_mul) begin
          {hi, lo} <= {1'b0, ({1'b0, hi[W-1:0]} + (lo[0] ? {1'b0, a_mag_q} : '0)),
                       lo[W-1:1]};
        end else if (!trial[W+1]) begin
          hi <= trial[W:0];
          lo <= {lo[W-2:0], 1'b1};
        end else begin
          hi <= {hi[W-1:0], lo[W-1]};
          lo <= {lo[W-2:0], 1'b0};
        end
      end
      if (cmd.mul_done) begin
        a_sign_q <= a_sign_q ^ op_sign;
        x_sign_q <= a_sign_q ^ op_sign;
        a_mag_q  <= hi[W-1:0];
        x_mag_q  <= lo;
      end
      if (cmd.div_done) begin
        // finish: quotient to rA, remainder to rX, overflow if pass one had quotient bits
        a_sign_q <= a_sign_q ^ op_sign;
        x_sign_q <= a_sign_q;
        a_mag_q  <= lo;
        x_mag_q  <= hi[W-1:0];
        if (qovf) ovf_q <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/miau_ctrl.sv
// Controller: sequences the item through setup, iterations and result.
module miau_ctrl
  import miau_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  miau_stat_t stat,
  output miau_cmd_t  cmd
);
  localparam int CntW = $clog2(WORD_BITS + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_DISP = 3'd1, S_ITER = 3'd2,
                         S_DIV2 = 3'd3, S_ITER2 = 3'd4, S_OUT = 3'd5,
                         S_FIN = 3'd6;

  logic [2:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        cnt_next = CntW'(WORD_BITS);
        if (stat.is_mul) begin
          cmd.mul_init = 1'b1;
          state_next   = S_ITER;
        end else if (stat.is_div) begin
          cmd.div_init = 1'b1;
          state_next   = stat.div_zero ? S_OUT : S_ITER;
        end else begin
          cmd.addsub = 1'b1;
          state_next = S_OUT;
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) state_next = stat.is_div ? S_DIV2 : S_FIN;
      end
      S_DIV2: begin
        cmd.div_pass2 = 1'b1;
        cnt_next      = CntW'(WORD_BITS);
        state_next    = S_ITER2;
      end
      S_ITER2: begin
        cmd.iter = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.is_mul) cmd.mul_done = 1'b1;
        else cmd.div_done = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

// File: rtl/core/miau_checker.sv
// Port-level checker for the MIX integer arithmetic unit, bound to the top.
module miau_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overflow_out
);
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(overflow_out) && !$past(rst) |-> overflow_out) else $error("overflow cleared");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind mix_integer_arithmetic_unit_top miau_checker u_miau_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .overflow_out
);
